/* rtl/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants for the lru key-value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;
    localparam int MAX_ENTRIES    = 16;
    localparam int KEY_BITS       = 16;
    localparam int VALUE_BITS     = 32;
    localparam int IDX_BITS       = $clog2(MAX_ENTRIES);
    localparam int AGE_BITS       = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_BITS       = 5;
    localparam int QUEUE_DEPTH    = 2;
    localparam logic [CAP_BITS-1:0] CAPACITY_RESET = CAP_BITS'(16);

    typedef enum logic {
        KIND_GET = 1'b0,
        KIND_PUT = 1'b1
    } t_kind;

    // one classified transaction between front and back
    typedef struct packed {
        t_kind                 kind;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_cmd;
endpackage

/* rtl/lru_key_value_cache_core.sv */
// path: an accepted get waits in the queue, then its result is registered by the table engine
// throughput: one transaction per cycle while results are taken
// the table engine does compare, age update and replacement in the same cycle
// reset: synchronous active-low; store empty, capacity 16, no clearing pass
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
module lru_key_value_cache_core (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [lkvc_pkg::CAP_BITS-1:0] i_cfg_wdata,
    input  logic i_valid,
    output logic o_stall,
    input  logic i_kind,
    input  logic [lkvc_pkg::KEY_BITS-1:0]   i_key,
    input  logic [lkvc_pkg::VALUE_BITS-1:0] i_value,
    output logic o_valid,
    input  logic i_stall,
    output logic o_hit,
    output logic [lkvc_pkg::VALUE_BITS-1:0] o_read_value
);
    import lkvc_pkg::*;

    logic [CAP_BITS-1:0] r_capacity;
    logic                cmd_valid, cmd_take;
    t_cmd                cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    lkvc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_kind, .i_key, .i_value,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    lkvc_back u_back (
        .i_clk, .i_rst_n, .i_capacity(r_capacity),
        .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_take(cmd_take),
        .o_valid, .i_stall, .o_hit, .o_read_value
    );
endmodule

/* rtl/lkvc_front.sv */
// ----------------------------------------------------------------------------
// lkvc_front
// input stage and a small command queue toward the table engine
// ----------------------------------------------------------------------------
module lkvc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_kind,
    input  logic [lkvc_pkg::KEY_BITS-1:0]   i_key,
    input  logic [lkvc_pkg::VALUE_BITS-1:0] i_value,
    output logic                  o_cmd_valid,
    output lkvc_pkg::t_cmd        o_cmd,
    input  logic                  i_cmd_take
);
    import lkvc_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    t_cmd                r_queue [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_BITS:0]   r_count;
    logic                push, pop;

    assign o_stall     = (r_count == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign pop         = o_cmd_valid && i_cmd_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= '{kind: t_kind'(i_kind), key: i_key, value: i_value};
        end
    end
endmodule

/* rtl/lkvc_back.sv */
// ----------------------------------------------------------------------------
// lkvc_back
// table engine: parallel key compare, age update, insert and evict
// ----------------------------------------------------------------------------
module lkvc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [lkvc_pkg::CAP_BITS-1:0] i_capacity,
    input  logic                  i_cmd_valid,
    input  lkvc_pkg::t_cmd        i_cmd,
    output logic                  o_cmd_take,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_hit,
    output logic [lkvc_pkg::VALUE_BITS-1:0] o_read_value
);
    import lkvc_pkg::*;

    logic                  r_valid_bits [MAX_ENTRIES];
    logic [KEY_BITS-1:0]   r_keys       [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] r_values     [MAX_ENTRIES];
    logic [AGE_BITS-1:0]   r_ages       [MAX_ENTRIES];
    logic [CNT_BITS-1:0]   r_live;
    logic                  r_out_valid, r_hit;
    logic [VALUE_BITS-1:0] r_read_value;

    logic [MAX_ENTRIES-1:0] match, oldest, is_free;
    logic                   hit_any, need_evict, do_op;
    logic [IDX_BITS-1:0]    hit_idx, old_idx, free_idx, ins_idx;
    logic [AGE_BITS-1:0]    hit_age;
    logic [VALUE_BITS-1:0]  hit_value;
    logic [CNT_BITS-1:0]    eff_cap;

    // a command is taken when the result register is empty or being taken, or when it is a put
    assign o_cmd_take = i_cmd_valid && (!r_out_valid || !i_stall
                        || i_cmd.kind == KIND_PUT);
    assign do_op      = o_cmd_take;

    always_comb begin
        if (i_capacity == '0)
            eff_cap = CNT_BITS'(1);
        else if (32'(i_capacity) > MAX_ENTRIES)
            eff_cap = CNT_BITS'(MAX_ENTRIES);
        else
            eff_cap = CNT_BITS'(i_capacity);
    end

    always_comb begin
        hit_any   = 1'b0;
        hit_idx   = '0;
        old_idx   = '0;
        free_idx  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match[i]   = r_valid_bits[i] && (r_keys[i] == i_cmd.key);
            // least recent holds the rank live-1
            oldest[i]  = r_valid_bits[i] && (CNT_BITS'(r_ages[i]) == r_live - 1'b1);
            is_free[i] = !r_valid_bits[i];
        end
        for (int i = MAX_ENTRIES-1; i >= 0; i--) begin
            if (match[i])   begin hit_any = 1'b1; hit_idx = IDX_BITS'(i); end
            if (oldest[i])  old_idx  = IDX_BITS'(i);
            if (is_free[i]) free_idx = IDX_BITS'(i);
        end
        hit_age    = r_ages[hit_idx];
        hit_value  = r_values[hit_idx];
        need_evict = (r_live >= eff_cap);
        ins_idx    = need_evict ? old_idx : free_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_valid_bits[i] <= 1'b0;
                r_ages[i]       <= '0;
            end
        end else begin
            if (do_op && i_cmd.kind == KIND_GET)
                r_out_valid <= 1'b1;
            else if (r_out_valid && !i_stall)
                r_out_valid <= 1'b0;
            if (do_op) begin
                if (hit_any) begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (r_valid_bits[i] && r_ages[i] < hit_age)
                            r_ages[i] <= r_ages[i] + 1'b1;
                    end
                    r_ages[hit_idx] <= '0;
                end else if (i_cmd.kind == KIND_PUT) begin
                    // evicted slot is reused; all others age by one
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (r_valid_bits[i] && !(need_evict && IDX_BITS'(i) == old_idx))
                            r_ages[i] <= r_ages[i] + 1'b1;
                    end
                    r_valid_bits[ins_idx] <= 1'b1;
                    r_ages[ins_idx]       <= '0;
                    if (!need_evict) r_live <= r_live + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_op) begin
            if (i_cmd.kind == KIND_GET) begin
                r_hit        <= hit_any;
                r_read_value <= hit_any ? hit_value : '0;
            end else if (hit_any) begin
                r_values[hit_idx] <= i_cmd.value;
            end else begin
                r_keys[ins_idx]   <= i_cmd.key;
                r_values[ins_idx] <= i_cmd.value;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_hit;
    assign o_read_value = r_read_value;
endmodule

/* rtl/lkvc_checker.sv */
// ----------------------------------------------------------------------------
// lkvc_checker
// port-level checks for the lru key-value cache
// ----------------------------------------------------------------------------
module lkvc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_hit,
    input logic [lkvc_pkg::VALUE_BITS-1:0] o_read_value
);
    import lkvc_pkg::*;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_read_value == '0) else $error("miss with data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_value) && $stable(o_hit))
        else $error("stalled result changed");

    a_no_stall_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall && !o_valid) else $error("busy after reset");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !$past(i_valid) && !$past(i_valid, 2) && $past(i_rst_n, 2)
        && !$past(o_stall) |=> !o_valid) else $error("result with no input");
endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall, .o_hit, .o_read_value
);

/* tb/tb_lru_key_value_cache_core.sv */
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_core
// gets and puts with random gaps and output stalls; a local lru model predicts
// every get result, which is compared field by field in arrival order
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_core;
    timeunit 1ns;
    timeprecision 1ps;
    import lkvc_pkg::*;

    typedef struct {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
    } t_lookup;

    class lru_scoreboard;
        logic                  valid_q [MAX_ENTRIES];
        logic [KEY_BITS-1:0]   key_q   [MAX_ENTRIES];
        logic [VALUE_BITS-1:0] val_q   [MAX_ENTRIES];
        int unsigned           age_q   [MAX_ENTRIES];
        int unsigned           live;
        int unsigned           capacity;
        t_lookup               pending_lookups [$];
        int unsigned           errors;
        int unsigned           hits;
        int unsigned           misses;
        int unsigned           evictions;

        function void clear();
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                valid_q[i] = 1'b0;
                age_q[i]   = 0;
            end
            live = 0;
            capacity = CAPACITY_RESET;
        endfunction

        function void set_capacity(logic [CAP_BITS-1:0] c);
            capacity = c;
        endfunction

        function void make_recent(int idx);
            int unsigned a;
            a = age_q[idx];
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (valid_q[i] && age_q[i] < a) age_q[i]++;
            age_q[idx] = 0;
        endfunction

        function void note_input(t_kind kind, logic [KEY_BITS-1:0] key,
                                 logic [VALUE_BITS-1:0] value);
            int idx;
            int oldest;
            int slot;
            int unsigned cap;
            t_lookup r;
            idx = -1;
            oldest = -1;
            slot = -1;
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (idx < 0 && valid_q[i] && key_q[i] == key) idx = i;
            if (kind == KIND_GET) begin
                r.hit = idx >= 0;
                r.read_value = '0;
                if (idx >= 0) begin
                    r.read_value = val_q[idx];
                    make_recent(idx);
                    hits++;
                end else begin
                    misses++;
                end
                pending_lookups.push_back(r);
                return;
            end
            if (idx >= 0) begin
                val_q[idx] = value;
                make_recent(idx);
                return;
            end
            cap = (capacity == 0) ? 1 : (capacity > MAX_ENTRIES ? MAX_ENTRIES : capacity);
            if (live >= cap || live >= MAX_ENTRIES) begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                    if (valid_q[i] && (oldest < 0 || age_q[i] > age_q[oldest])) oldest = i;
                if (oldest >= 0) begin
                    valid_q[oldest] = 1'b0;
                    age_q[oldest] = 0;
                    live--;
                    evictions++;
                end
            end
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (slot < 0 && !valid_q[i]) slot = i;
            if (slot < 0) return;
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (valid_q[i]) age_q[i]++;
            valid_q[slot] = 1'b1;
            key_q[slot] = key;
            val_q[slot] = value;
            age_q[slot] = 0;
            live++;
        endfunction

        function void check_result(logic hit, logic [VALUE_BITS-1:0] read_value);
            t_lookup e;
            if (pending_lookups.size() == 0) begin
                $display("%0t: unexpected result hit=%0b value=%h", $time, hit, read_value);
                errors++;
                return;
            end
            e = pending_lookups.pop_front();
            if (hit !== e.hit) begin
                $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
                errors++;
            end
            if (read_value !== e.read_value) begin
                $display("%0t: read_value expected %h actual %h", $time, e.read_value,
                         read_value);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CAP_BITS-1:0] i_cfg_wdata = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_kind = 1'b0;
    logic [KEY_BITS-1:0] i_key = '0;
    logic [VALUE_BITS-1:0] i_value = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_hit;
    logic [VALUE_BITS-1:0] o_read_value;

    lru_scoreboard sb;
    int unsigned sent;
    bit sender_gaps = 1'b1;
    bit receiver_gaps = 1'b1;
    bit hold_long = 1'b0;
    logic [KEY_BITS-1:0] key_pool [8];

    lru_key_value_cache_core dut (.*);

    always #6 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("tb_lru_key_value_cache_core NOT OK");
        $finish;
    end

    // output side: check accepted results and draw stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_hit, o_read_value);
    end

    initial begin : receiver
        int unsigned n;
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                i_stall <= 1'b1;
                repeat (200) @(posedge i_clk);
                i_stall <= 1'b0;
                wait (!hold_long);
            end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(0, 19);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send(t_kind kind, logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] value);
        int unsigned gap;
        gap = sender_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0 && $urandom_range(0, 2) != 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_key   <= key;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(kind, key, value);
        sent++;
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_lookups.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_BITS-1:0] c);
        go_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_capacity(c);
    endtask

    task automatic random_phase(int unsigned count);
        t_kind k;
        logic [KEY_BITS-1:0] key;
        for (int unsigned n = 0; n < count; n++) begin
            k = t_kind'($urandom_range(0, 1));
            // mostly keys from a small pool so that hits and evictions happen
            key = ($urandom_range(0, 9) == 0) ? KEY_BITS'($urandom)
                                              : key_pool[$urandom_range(0, 7)];
            send(k, key, $urandom);
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, miss on empty store, update of present key, eviction
        send(KIND_GET, '0, '0);
        send(KIND_PUT, '0, '0);
        send(KIND_PUT, '1, '1);
        send(KIND_GET, '0, '1);
        send(KIND_GET, '1, '0);
        send(KIND_PUT, '0, 32'h5555_aaaa);
        send(KIND_GET, '0, '0);
        write_capacity(5'd1);
        send(KIND_PUT, 16'h1234, 32'hdead_beef);
        send(KIND_GET, '1, '0);
        send(KIND_GET, 16'h1234, '0);
        send(KIND_PUT, 16'h1234, 32'h0bad_f00d);
        send(KIND_GET, 16'h1234, '0);
        write_capacity(5'd0);
        send(KIND_PUT, 16'h8000, 32'h8000_0001);
        send(KIND_GET, 16'h8000, '0);
        write_capacity(5'd31);
        for (int i = 0; i < 18; i++) send(KIND_PUT, KEY_BITS'(i * 4097), $urandom);
        send(KIND_GET, 16'd0, '0);
        send(KIND_GET, 16'd8194, '0);

        for (int phase = 0; phase < 6; phase++) begin
            foreach (key_pool[i]) key_pool[i] = KEY_BITS'($urandom_range(0, 23));
            key_pool[0] = KEY_BITS'($urandom);
            case (phase)
                0: write_capacity(5'd16);
                1: write_capacity(5'd3);
                2: write_capacity(5'd17);
                3: write_capacity(5'd2);
                4: write_capacity(5'd8);
                default: write_capacity(CAP_BITS'($urandom_range(0, 31)));
            endcase
            if (phase == 2) begin
                hold_long = 1'b1;
                sender_gaps = 1'b0;
                random_phase(60);
                hold_long = 1'b0;
                sender_gaps = 1'b1;
            end
            if (phase == 4) begin
                receiver_gaps = 1'b0;
                sender_gaps = 1'b0;
                random_phase(100);
                receiver_gaps = 1'b1;
                sender_gaps = 1'b1;
            end
            random_phase(230);
            // sender waits for every outstanding result
            go_idle();
        end

        go_idle();
        repeat (10) @(posedge i_clk);
        $display("covered %0d transactions: %0d hits, %0d misses, %0d evictions",
                 sent, sb.hits, sb.misses, sb.evictions);
        $display("capacities from 0 to 31 written, long output hold and quiet stretches");
        if (sb.errors == 0 && sb.pending_lookups.size() == 0)
            $display("tb_lru_key_value_cache_core OK");
        else
            $display("tb_lru_key_value_cache_core NOT OK");
        $finish;
    end
endmodule

/* sim.f */
rtl/lkvc_pkg.sv
rtl/lkvc_front.sv
rtl/lkvc_back.sv
rtl/lru_key_value_cache_core.sv
rtl/lkvc_checker.sv
tb/tb_lru_key_value_cache_core.sv
